[src/wtfa_pkg.sv]
package wtfa_pkg;

  // Batch length limit
  localparam int MAX_DAYS   = 30;
  localparam int NCH        = 4;
  localparam int DATA_W     = 16;
  localparam int DAY_W      = $clog2(MAX_DAYS + 1);
  localparam int MAX_WT     = MAX_DAYS * (MAX_DAYS + 1) / 2;
  localparam int WT_W       = $clog2(MAX_WT + 1);
  localparam int SUM_W      = DATA_W + WT_W;
  localparam int STEP_W     = $clog2(SUM_W + 1);
  localparam int DAYS_OUT_W = 5;
  localparam int CFG_IDX_W  = 8;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PM25 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NO2  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SO2  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CO2  = CFG_IDX_W'(3);

  localparam logic [DATA_W-1:0] PM25_LIMIT_RST = 16'd3840;
  localparam logic [DATA_W-1:0] NO2_LIMIT_RST  = 16'd6400;
  localparam logic [DATA_W-1:0] SO2_LIMIT_RST  = 16'd10240;
  localparam logic [DATA_W-1:0] CO2_LIMIT_RST  = 16'd1024;

  typedef logic [DATA_W-1:0] q88_t;
  typedef logic [NCH-1:0][DATA_W-1:0] quad_t;

  // Shared lane control from the sequencer
  typedef struct packed {
    logic             acc;
    logic             step;
    logic             clear;
    logic [DAY_W-1:0] weight;
  } lane_ctrl_t;

endpackage

[src/wtfa_in_if.sv]
interface wtfa_in_if;
  import wtfa_pkg::*;
  logic valid;
  logic ready;
  q88_t pm25_sample;
  q88_t no2_sample;
  q88_t so2_sample;
  q88_t co2_sample;
  logic last_day;

  modport source (output valid, pm25_sample, no2_sample, so2_sample, co2_sample,
                  last_day, input ready);
  modport sink (input valid, pm25_sample, no2_sample, so2_sample, co2_sample,
                last_day, output ready);
endinterface

[src/wtfa_out_if.sv]
interface wtfa_out_if;
  import wtfa_pkg::*;
  logic                  valid;
  logic                  ready;
  q88_t                  pm25_forecast;
  q88_t                  no2_forecast;
  q88_t                  so2_forecast;
  q88_t                  co2_forecast;
  logic [NCH-1:0]        alert_mask;
  logic [DAYS_OUT_W-1:0] days_used;

  modport source (output valid, pm25_forecast, no2_forecast, so2_forecast,
                  co2_forecast, alert_mask, days_used, input ready);
  modport sink (input valid, pm25_forecast, no2_forecast, so2_forecast,
                co2_forecast, alert_mask, days_used, output ready);
endinterface

[src/wtfa_cfg_if.sv]
interface wtfa_cfg_if;
  import wtfa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  q88_t                 data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/wtfa_lane.sv]
// One channel: weighted accumulate, then restoring divide in place.
// After SUM_W steps acc holds the quotient.
module wtfa_lane
  import wtfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lane_ctrl_t        ctrl,
  input  q88_t              sample,
  input  logic [WT_W-1:0]   divisor,
  output q88_t              quotient
);

  logic [SUM_W-1:0] acc;
  logic [WT_W-1:0]  rem;
  logic [SUM_W-1:0] product;
  logic [WT_W:0]    rem_sh;
  logic             fits;

  assign product = SUM_W'(sample) * SUM_W'(ctrl.weight);
  assign rem_sh  = {rem, acc[SUM_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
      rem <= '0;
    end else if (ctrl.acc) begin
      acc <= acc + product;
    end else if (ctrl.step) begin
      acc <= {acc[SUM_W-2:0], fits};
      rem <= fits ? WT_W'(rem_sh - {1'b0, divisor}) : WT_W'(rem_sh);
    end
  end

  assign quotient = acc[DATA_W-1:0];

endmodule

[src/wtfa_merge.sv]
// Collects lane forecasts, flags those strictly above their limits.
module wtfa_merge
  import wtfa_pkg::*;
(
  input  quad_t          forecasts,
  input  quad_t          limits,
  output logic [NCH-1:0] alert_mask
);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      alert_mask[c] = forecasts[c] > limits[c];
    end
  end

endmodule

[src/weighted_trend_forecast_alerts.sv]
// Channel   Dir   Payload                                         Accepted when
// samples   sink  pm25/no2/so2/co2_sample (Q8.8), last_day        valid & ready
// results   src   pm25/no2/so2/co2_forecast, alert_mask, days_used valid & ready
// cfg       sink  index, data (limit register write)              valid & ready
//
// Samples: one item per cycle while a batch accumulates.
// The item with last_day starts a SUM_W-step restoring divide run by four lanes
// side by side, then the result is loaded: samples.ready is low from that item
// until the load.
// The load waits until the output register is free, so samples.ready stays low
// longer while an earlier result sits untaken there.
// rst is synchronous; it clears sums, counts and restores the limit defaults.
module weighted_trend_forecast_alerts
  import wtfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  wtfa_in_if.sink    samples,
  wtfa_out_if.source results,
  wtfa_cfg_if.sink   cfg
);

  localparam logic ST_ACC = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic              state;
  logic [STEP_W-1:0] step_cnt;
  logic [DAY_W-1:0]  day_count;
  logic [WT_W-1:0]   weight_total;
  quad_t             limits;

  logic              in_fire;
  logic              room;
  logic              div_done;
  logic              out_free;
  logic              load_out;
  logic [DAY_W-1:0]  weight;
  lane_ctrl_t        ctrl;
  quad_t             sample_v;
  quad_t             quot_v;
  logic [NCH-1:0]    mask;

  // Config: limits only, always ready; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits[0] <= PM25_LIMIT_RST;
      limits[1] <= NO2_LIMIT_RST;
      limits[2] <= SO2_LIMIT_RST;
      limits[3] <= CO2_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PM25: limits[0] <= cfg.data;
        REG_NO2:  limits[1] <= cfg.data;
        REG_SO2:  limits[2] <= cfg.data;
        REG_CO2:  limits[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer
  assign samples.ready = (state == ST_ACC);
  assign in_fire       = samples.valid && samples.ready;
  assign room          = day_count < DAY_W'(MAX_DAYS);
  assign weight        = day_count + DAY_W'(1);
  assign div_done      = step_cnt == STEP_W'(SUM_W);
  assign out_free      = !results.valid || results.ready;
  assign load_out      = (state == ST_DIV) && div_done && out_free;

  assign ctrl.acc    = in_fire && room;
  assign ctrl.step   = (state == ST_DIV) && !div_done;
  assign ctrl.clear  = load_out;
  assign ctrl.weight = weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACC;
      step_cnt     <= '0;
      day_count    <= '0;
      weight_total <= '0;
    end else begin
      case (state)
        ST_ACC: begin
          if (ctrl.acc) begin
            day_count    <= weight;
            weight_total <= weight_total + WT_W'(weight);
          end
          if (in_fire && samples.last_day) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ctrl.step) begin
            step_cnt <= step_cnt + STEP_W'(1);
          end else if (load_out) begin
            state        <= ST_ACC;
            step_cnt     <= '0;
            day_count    <= '0;
            weight_total <= '0;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  // Lanes
  assign sample_v[0] = samples.pm25_sample;
  assign sample_v[1] = samples.no2_sample;
  assign sample_v[2] = samples.so2_sample;
  assign sample_v[3] = samples.co2_sample;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    wtfa_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sample   (sample_v[c]),
      .divisor  (weight_total),
      .quotient (quot_v[c])
    );
  end

  wtfa_merge u_merge (
    .forecasts  (quot_v),
    .limits     (limits),
    .alert_mask (mask)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load_out) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.pm25_forecast <= quot_v[0];
      results.no2_forecast  <= quot_v[1];
      results.so2_forecast  <= quot_v[2];
      results.co2_forecast  <= quot_v[3];
      results.alert_mask    <= mask;
      results.days_used     <= DAYS_OUT_W'(day_count);
    end
  end

  // Checks
  a_day_bound: assert property (@(posedge clk) disable iff (rst)
    int'(day_count) <= MAX_DAYS)
    else $error("day count past limit");

  a_wt_sum: assert property (@(posedge clk) disable iff (rst)
    2 * int'(weight_total) == int'(day_count) * (int'(day_count) + 1))
    else $error("weight total out of step with day count");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    int'(step_cnt) <= SUM_W)
    else $error("divide step counter overrun");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (day_count == '0) && (state == ST_ACC) && results.valid)
    else $error("batch not cleared after result load");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (weight_total != '0))
    else $error("divide with zero weight");

endmodule

[dv/tb_weighted_trend_forecast_alerts.sv]
`timescale 1ns / 100ps

import wtfa_pkg::*;

// One day of samples as the testbench sees it: lane 0 PM2.5, 1 NO2, 2 SO2, 3 CO2
typedef struct packed {
  quad_t sample;
  logic  last_day;
} day_t;

// One forecast item, lanes in the same order as day_t
typedef struct packed {
  quad_t                 forecast;
  logic [NCH-1:0]        alert_mask;
  logic [DAYS_OUT_W-1:0] days_used;
} forecast_t;

// Tracks the weighted sums of the open batch and keeps the forecasts still owed.
class forecast_board;
  q88_t             limit [NCH];
  logic [SUM_W-1:0] wsum [NCH];
  logic [DAY_W-1:0] days;
  logic [WT_W-1:0]  wt;
  forecast_t        due [$];
  int               errors;

  function new();
    limit[0] = PM25_LIMIT_RST;
    limit[1] = NO2_LIMIT_RST;
    limit[2] = SO2_LIMIT_RST;
    limit[3] = CO2_LIMIT_RST;
    errors = 0;
    clear_batch();
  endfunction

  function void clear_batch();
    for (int c = 0; c < NCH; c++) wsum[c] = '0;
    days = '0;
    wt = '0;
  endfunction

  function int waiting();
    return due.size();
  endfunction

  function void set_limit(logic [CFG_IDX_W-1:0] idx, q88_t val);
    case (idx)
      REG_PM25: limit[0] = val;
      REG_NO2:  limit[1] = val;
      REG_SO2:  limit[2] = val;
      REG_CO2:  limit[3] = val;
      default: ;
    endcase
  endfunction

  // Accepted day: weight k for the k-th day, days past MAX_DAYS dropped
  function void note_day(day_t d);
    logic [DAY_W-1:0] w;
    logic [SUM_W-1:0] q;
    forecast_t        want;
    if (int'(days) < MAX_DAYS) begin
      w = days + 1'b1;
      for (int c = 0; c < NCH; c++)
        wsum[c] = wsum[c] + SUM_W'(d.sample[c]) * SUM_W'(w);
      wt = wt + WT_W'(w);
      days = w;
    end
    if (d.last_day) begin
      want = '0;
      for (int c = 0; c < NCH; c++) begin
        q = (wt == '0) ? '0 : wsum[c] / SUM_W'(wt);
        want.forecast[c] = q[DATA_W-1:0];
        want.alert_mask[c] = (want.forecast[c] > limit[c]);
      end
      want.days_used = DAYS_OUT_W'(days);
      due.push_back(want);
      clear_batch();
    end
  endfunction

  task report(string msg);
    $display("%0t ERROR %s", $time, msg);
    errors++;
  endtask

  task check_forecast(forecast_t got);
    forecast_t want;
    string     lbl [NCH];
    lbl = '{"pm25", "no2", "so2", "co2"};
    if (due.size() == 0) begin
      report("forecast item with none pending");
      return;
    end
    want = due.pop_front();
    for (int c = 0; c < NCH; c++)
      if (got.forecast[c] !== want.forecast[c])
        report($sformatf("%s_forecast got %0d want %0d", lbl[c], got.forecast[c],
                         want.forecast[c]));
    if (got.alert_mask !== want.alert_mask)
      report($sformatf("alert_mask got %b want %b", got.alert_mask, want.alert_mask));
    if (got.days_used !== want.days_used)
      report($sformatf("days_used got %0d want %0d", got.days_used, want.days_used));
  endtask
endclass

module tb_weighted_trend_forecast_alerts;

  logic clk;
  logic rst;

  // Idle odds in percent: sender gaps and result back-pressure
  int send_idle;
  int recv_stall;

  forecast_board board;
  day_t          took;
  forecast_t     seen;

  wtfa_in_if  samples_if ();
  wtfa_out_if results_if ();
  wtfa_cfg_if cfg_if ();

  weighted_trend_forecast_alerts dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #3000000;
    $display("tb_weighted_trend_forecast_alerts failed");
    $finish;
  end

  // Result back-pressure, redrawn every cycle
  always @(posedge clk) results_if.ready <= ($urandom_range(99) >= recv_stall);

  // Monitors: everything sampled at the edge sees pre-edge values, since all
  // drivers update with nonblocking assignments.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready)
        board.set_limit(cfg_if.index, cfg_if.data);
      if (samples_if.valid && samples_if.ready) begin
        took.sample[0] = samples_if.pm25_sample;
        took.sample[1] = samples_if.no2_sample;
        took.sample[2] = samples_if.so2_sample;
        took.sample[3] = samples_if.co2_sample;
        took.last_day  = samples_if.last_day;
        board.note_day(took);
      end
      if (results_if.valid && results_if.ready) begin
        seen.forecast[0] = results_if.pm25_forecast;
        seen.forecast[1] = results_if.no2_forecast;
        seen.forecast[2] = results_if.so2_forecast;
        seen.forecast[3] = results_if.co2_forecast;
        seen.alert_mask  = results_if.alert_mask;
        seen.days_used   = results_if.days_used;
        board.check_forecast(seen);
      end
    end
  end

  function automatic day_t day_of(q88_t pm25, q88_t no2, q88_t so2, q88_t co2,
                                  logic last);
    day_t d;
    d.sample[0] = pm25;
    d.sample[1] = no2;
    d.sample[2] = so2;
    d.sample[3] = co2;
    d.last_day  = last;
    return d;
  endfunction

  // Mix of extremes, full-range noise and values close to a chosen center,
  // so forecasts land on both sides of the alert limits.
  function automatic q88_t pick_sample(q88_t ctr);
    int r;
    int v;
    r = $urandom_range(9);
    case (r)
      0: v = 0;
      1: v = 65535;
      2, 3, 4: v = int'($urandom_range(65535));
      default: v = int'(ctr) + int'($urandom_range(64)) - 32;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return q88_t'(v);
  endfunction

  // Present one day and hold it until it is taken; valid stays high after
  // the accepting edge unless the next call idles.
  task automatic send_day(day_t d);
    while ($urandom_range(99) < send_idle) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid       <= 1'b1;
    samples_if.pm25_sample <= d.sample[0];
    samples_if.no2_sample  <= d.sample[1];
    samples_if.so2_sample  <= d.sample[2];
    samples_if.co2_sample  <= d.sample[3];
    samples_if.last_day    <= d.last_day;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  // Stop sending until every owed forecast is back. Waits on the clock first so a day
  // taken on the current edge is already on the board.
  task automatic hold_for_forecasts();
    samples_if.valid <= 1'b0;
    do @(posedge clk); while (board.waiting() != 0);
  endtask

  // Quiet point before a limit change: drained, then the divider's latency
  task automatic settle();
    hold_for_forecasts();
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, q88_t val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Writes all four limits, preceded by a write to an unmapped index that
  // must leave them alone.
  task automatic program_limits(q88_t pm25, q88_t no2, q88_t so2, q88_t co2);
    write_reg(CFG_IDX_W'($urandom_range(255, NCH)), q88_t'($urandom));
    write_reg(REG_PM25, pm25);
    write_reg(REG_NO2, no2);
    write_reg(REG_SO2, so2);
    write_reg(REG_CO2, co2);
    cfg_if.valid <= 1'b0;
  endtask

  // Random batches: mostly short, some near, at or past MAX_DAYS so the overflow
  // rule gets exercised. Each batch has its own per-lane center.
  task automatic run_days(int n_items);
    int   sent;
    int   len;
    int   r;
    q88_t ctr [NCH];
    day_t d;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(6, 1);
      else if (r < 85) len = $urandom_range(20, 7);
      else if (r < 93) len = $urandom_range(MAX_DAYS, MAX_DAYS - 2);
      else len = $urandom_range(MAX_DAYS + 10, MAX_DAYS + 1);
      for (int c = 0; c < NCH; c++)
        ctr[c] = $urandom_range(1) ? board.limit[c] : q88_t'($urandom);
      for (int k = 1; k <= len; k++) begin
        for (int c = 0; c < NCH; c++) d.sample[c] = pick_sample(ctr[c]);
        d.last_day = (k == len);
        send_day(d);
        sent++;
      end
      // now and then let the output side drain completely
      if ($urandom_range(49) == 0) hold_for_forecasts();
    end
  endtask

  initial begin
    rst                    = 1'b1;
    send_idle              = 21;
    recv_stall             = 57;
    samples_if.valid       = 1'b0;
    samples_if.pm25_sample = '0;
    samples_if.no2_sample  = '0;
    samples_if.so2_sample  = '0;
    samples_if.co2_sample  = '0;
    samples_if.last_day    = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = '0;
    cfg_if.data            = '0;
    board = new();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, at reset limits
    // one-day batches: floor, ceiling, exactly at limit, one above limit
    send_day(day_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_day(day_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_day(day_of(PM25_LIMIT_RST, NO2_LIMIT_RST, SO2_LIMIT_RST, CO2_LIMIT_RST, 1'b1));
    send_day(day_of(PM25_LIMIT_RST + 1'b1, NO2_LIMIT_RST + 1'b1, SO2_LIMIT_RST + 1'b1,
                    CO2_LIMIT_RST + 1'b1, 1'b1));
    // two days, newest weighs double: rising and falling trends
    send_day(day_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_day(day_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_day(day_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_day(day_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    // alternating bit patterns
    send_day(day_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0));
    send_day(day_of(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1));
    // three days straddling the limits, truncation shows in the low bits
    send_day(day_of(16'd3839, 16'd6401, 16'd10241, 16'd1023, 1'b0));
    send_day(day_of(16'd3842, 16'd6399, 16'd10240, 16'd1025, 1'b0));
    send_day(day_of(16'd3840, 16'd6400, 16'd10239, 16'd1024, 1'b1));
    run_days(300);

    // Phase: limits at zero, anything nonzero alerts
    settle();
    program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_days(300);

    // Sender and receiver idle odds swapped
    settle();
    send_idle  = 57;
    recv_stall = 21;
    program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_days(300);
    settle();
    program_limits(q88_t'($urandom), q88_t'($urandom), q88_t'($urandom), q88_t'($urandom));
    run_days(300);

    // Full rate on both sides
    settle();
    send_idle  = 0;
    recv_stall = 0;
    program_limits(q88_t'($urandom), q88_t'($urandom), q88_t'($urandom), q88_t'($urandom));
    run_days(300);
    settle();
    program_limits(PM25_LIMIT_RST, NO2_LIMIT_RST, SO2_LIMIT_RST, CO2_LIMIT_RST);
    run_days(300);

    settle();
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("tb_weighted_trend_forecast_alerts passed");
    end else begin
      $display("tb_weighted_trend_forecast_alerts failed");
    end
    $finish;
  end

endmodule
